### rtl/tdsch_pkg.sv
// Shared constants and types of the typed task dispatch scheduler.
package tdsch_pkg;

  localparam int WAIT_DEPTH = 512;
  localparam int RUN_SLOTS  = 3;
  localparam int TYPE_COUNT = 8;

  localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
  localparam int ADDR_W = $clog2(WAIT_DEPTH);
  localparam int SLOT_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int TYPE_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [1:0] KIND_ADDED    = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;
  localparam logic [1:0] KIND_STARTED  = 2'd3;

  typedef struct packed {
    logic [2:0]  job_type;
    logic [31:0] prereq_seq;
    logic [31:0] seq;
  } wait_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [2:0]  task_type;
    logic [1:0]  run_slot;
  } result_t;

endpackage

### rtl/tdsch_if.sv
// Request and response channel interfaces of the scheduler.
interface tdsch_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  job_type;
  logic [31:0] prereq_seq;
  logic [1:0]  slot;
  modport source (output valid, cmd, job_type, prereq_seq, slot, input ready);
  modport sink (input valid, cmd, job_type, prereq_seq, slot, output ready);
endinterface

interface tdsch_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] seq;
  logic [2:0]  task_type;
  logic [1:0]  run_slot;
  logic        last;
  modport source (output valid, kind, seq, task_type, run_slot, last, input ready);
  modport sink (input valid, kind, seq, task_type, run_slot, last, output ready);
endinterface

### rtl/tdsch_wait_store.sv
// Wait store memory: one write port, one read port with registered data.
module tdsch_wait_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [tdsch_pkg::ADDR_W-1:0] waddr,
  input  tdsch_pkg::wait_entry_t      wdata,
  input  logic [tdsch_pkg::ADDR_W-1:0] raddr,
  output tdsch_pkg::wait_entry_t      rdata
);
  import tdsch_pkg::*;

  wait_entry_t mem [WAIT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/typed_task_dispatch_scheduler.sv
// Typed task dispatch scheduler top level.
// One request is handled at a time; each accepted add or finish runs a dispatch pass.
// The pass visits up to 8 types; each type with no running task scans the wait store
// entry by entry, a prerequisite check scans it once more, and a start compacts the
// store one moved entry at a time. The store has a single read port.
// Synchronous reset empties the store, frees all slots and clears the counter.
module typed_task_dispatch_scheduler (
  input logic clk,
  input logic rst,
  tdsch_req_if.sink   req,
  tdsch_rsp_if.source rsp
);
  import tdsch_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_T_RD  = 4'd2;
  localparam logic [3:0] S_T_CHK = 4'd3;
  localparam logic [3:0] S_P_RD  = 4'd4;
  localparam logic [3:0] S_P_CHK = 4'd5;
  localparam logic [3:0] S_START = 4'd6;
  localparam logic [3:0] S_M_RD  = 4'd7;
  localparam logic [3:0] S_M_WR  = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;

  logic [3:0]        state;
  logic [CNT_W-1:0]  wait_count;
  logic [CNT_W-1:0]  idx;       // scan position or compaction position
  logic [CNT_W-1:0]  pidx;      // prerequisite scan position
  logic [31:0]       seq_counter;
  logic [TYPE_W-1:0] ptr;       // last searched type
  logic [TYPE_W:0]   visited;   // types visited in this pass
  logic [31:0]       cand_seq;
  logic [31:0]       cand_prereq;
  logic              slot_busy [RUN_SLOTS];
  logic [31:0]       slot_seq  [RUN_SLOTS];
  logic [TYPE_W-1:0] slot_type [RUN_SLOTS];

  // The newest result is held back until the next one appears or the pass
  // ends, so that the last flag can be set on the final transfer.
  result_t pend;
  result_t out_q;
  logic    out_valid;
  logic    out_last;
  logic    out_free;
  logic    out_load;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  wait_entry_t       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  wait_entry_t       mem_rdata;

  tdsch_wait_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Slot summary: lowest free slot, all-busy flag, type of the next search.
  logic              all_busy;
  logic [SLOT_W-1:0] free_slot;
  logic [TYPE_W-1:0] ptr_next;
  logic              type_running;
  logic              prereq_running;
  logic [CNT_W-1:0]  idx_inc;
  logic [31:0]       seq_next;

  always_comb begin
    all_busy       = 1'b1;
    free_slot      = '0;
    type_running   = 1'b0;
    prereq_running = 1'b0;
    for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        all_busy  = 1'b0;
        free_slot = SLOT_W'(i);
      end
    end
    ptr_next = (ptr == TYPE_W'(TYPE_COUNT - 1)) ? '0 : ptr + 1'b1;
    for (int i = 0; i < RUN_SLOTS; i++) begin
      if (slot_busy[i] && slot_type[i] == ptr_next) type_running = 1'b1;
      if (slot_busy[i] && slot_seq[i] == mem_rdata.prereq_seq) prereq_running = 1'b1;
    end
    idx_inc  = idx + 1'b1;
    seq_next = (seq_counter == 32'hFFFF_FFFF) ? 32'd1 : seq_counter + 1'b1;
  end

  assign out_free  = !out_valid || rsp.ready;
  // A result is loaded into the output register when a start replaces the held
  // result or when the pass ends and the held result goes out as the last one.
  assign out_load  = out_free && (state == S_START || state == S_FLUSH);
  assign req.ready = (state == S_IDLE);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[ADDR_W-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        mem_we    = req.valid && req.cmd == CMD_ADD && wait_count < CNT_W'(WAIT_DEPTH)
                    && 32'(req.job_type) < 32'(TYPE_COUNT);
        mem_waddr = wait_count[ADDR_W-1:0];
        mem_wdata = '{job_type: req.job_type, prereq_seq: req.prereq_seq,
                      seq: seq_next};
      end
      S_P_RD:  mem_raddr = pidx[ADDR_W-1:0];
      S_M_RD:  mem_raddr = idx_inc[ADDR_W-1:0];
      S_M_WR:  mem_we    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wait_count  <= '0;
      seq_counter <= '0;
      ptr         <= TYPE_W'(TYPE_COUNT - 1);
      out_valid   <= 1'b0;
      for (int i = 0; i < RUN_SLOTS; i++) begin
        slot_busy[i] <= 1'b0;
        slot_seq[i]  <= '0;
        slot_type[i] <= '0;
      end
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          visited <= '0;
          if (req.valid) begin
            if (req.cmd == CMD_ADD) begin
              if (mem_we) begin
                seq_counter <= seq_next;
                wait_count  <= wait_count + 1'b1;
                pend        <= '{kind: KIND_ADDED, seq: seq_next, default: '0};
                state       <= S_DISP;
              end else begin
                pend  <= '{kind: KIND_REJECTED, default: '0};
                state <= S_FLUSH;
              end
            end else begin
              if (32'(req.slot) < 32'(RUN_SLOTS)) slot_busy[SLOT_W'(req.slot)] <= 1'b0;
              pend  <= '{kind: KIND_FINISHED, default: '0};
              state <= S_DISP;
            end
          end
        end
        S_DISP: begin
          if (all_busy || visited == (TYPE_W + 1)'(TYPE_COUNT)) begin
            state <= S_FLUSH;
          end else begin
            ptr     <= ptr_next;
            visited <= visited + 1'b1;
            idx     <= '0;
            if (!type_running) state <= S_T_RD;
          end
        end
        S_T_RD: state <= (idx >= wait_count) ? S_DISP : S_T_CHK;
        S_T_CHK: begin
          if (mem_rdata.job_type != 3'(ptr)) begin
            idx   <= idx_inc;
            state <= S_T_RD;
          end else begin
            cand_seq    <= mem_rdata.seq;
            cand_prereq <= mem_rdata.prereq_seq;
            pidx        <= '0;
            if (mem_rdata.prereq_seq == '0) state <= S_START;
            else if (prereq_running) state <= S_DISP;
            else state <= S_P_RD;
          end
        end
        S_P_RD: state <= (pidx >= wait_count) ? S_START : S_P_CHK;
        S_P_CHK: begin
          if (mem_rdata.seq == cand_prereq) begin
            state <= S_DISP;
          end else begin
            pidx  <= pidx + 1'b1;
            state <= S_P_RD;
          end
        end
        S_START: begin
          // The held result goes out before the start result replaces it.
          if (out_free) begin
            out_q     <= pend;
            out_last  <= 1'b0;
            pend      <= '{kind: KIND_STARTED, seq: cand_seq, task_type: 3'(ptr),
                           run_slot: 2'(free_slot)};
            slot_busy[free_slot] <= 1'b1;
            slot_seq[free_slot]  <= cand_seq;
            slot_type[free_slot] <= ptr;
            state <= S_M_RD;
          end
        end
        S_M_RD: begin
          // Close the gap left by the started task, one entry at a time.
          if (idx_inc >= wait_count) begin
            wait_count <= wait_count - 1'b1;
            state      <= S_DISP;
          end else begin
            state <= S_M_WR;
          end
        end
        S_M_WR: begin
          idx   <= idx_inc;
          state <= S_M_RD;
        end
        S_FLUSH: begin
          if (out_free) begin
            out_q     <= pend;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.kind      = out_q.kind;
  assign rsp.seq       = out_q.seq;
  assign rsp.task_type = out_q.task_type;
  assign rsp.run_slot  = out_q.run_slot;
  assign rsp.last      = out_last;

endmodule

### sim/tdsch_checker.sv
// Scoreboard for the scheduler: predicts results of accepted requests and compares them.
module tdsch_checker (
  input  logic        clk,
  input  logic        rst,
  tdsch_req_if        req,
  tdsch_rsp_if        rsp,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdsch_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [2:0]  task_type;
    logic [1:0]  run_slot;
    logic        last;
  } outcome_t;

  outcome_t    expected_q[$];
  logic [31:0] w_seq[$];
  logic [31:0] w_pre[$];
  logic [2:0]  w_type[$];
  logic        s_busy[RUN_SLOTS];
  logic [31:0] s_seq[RUN_SLOTS];
  logic [2:0]  s_type[RUN_SLOTS];
  logic [2:0]  rr_type;
  logic [31:0] seq_ctr;

  function automatic outcome_t mk(logic [1:0] k, logic [31:0] s, logic [2:0] t,
                                  logic [1:0] r);
    outcome_t o;
    o.kind = k; o.seq = s; o.task_type = t; o.run_slot = r; o.last = 1'b0;
    return o;
  endfunction

  function automatic bit still_present(logic [31:0] s);
    foreach (s_busy[i]) if (s_busy[i] && s_seq[i] == s) return 1;
    foreach (w_seq[i]) if (w_seq[i] == s) return 1;
    return 0;
  endfunction

  task automatic run_dispatch_pass();
    int busy;
    int free_slot;
    bit running;
    for (int n = 0; n < TYPE_COUNT; n++) begin
      busy = 0;
      free_slot = -1;
      for (int i = 0; i < RUN_SLOTS; i++) begin
        if (s_busy[i]) busy++;
        else if (free_slot < 0) free_slot = i;
      end
      if (busy >= RUN_SLOTS) return;
      rr_type = rr_type + 3'd1;
      running = 0;
      for (int i = 0; i < RUN_SLOTS; i++)
        if (s_busy[i] && s_type[i] == rr_type) running = 1;
      if (running) continue;
      for (int i = 0; i < w_seq.size(); i++) begin
        if (w_type[i] != rr_type) continue;
        if (w_pre[i] != 0 && still_present(w_pre[i])) break;
        s_busy[free_slot] = 1'b1;
        s_seq[free_slot] = w_seq[i];
        s_type[free_slot] = rr_type;
        expected_q.insert(expected_q.size(),
                          mk(KIND_STARTED, w_seq[i], rr_type, free_slot[1:0]));
        w_seq.delete(i);
        w_pre.delete(i);
        w_type.delete(i);
        break;
      end
    end
  endtask

  task automatic predict_request();
    if (req.cmd == CMD_ADD) begin
      if (w_seq.size() >= WAIT_DEPTH) begin
        outcome_t o;
        o = mk(KIND_REJECTED, '0, '0, '0);
        o.last = 1'b1;
        expected_q.insert(expected_q.size(), o);
        return;
      end
      seq_ctr = seq_ctr + 1;
      if (seq_ctr == 0) seq_ctr = 1;
      w_seq.insert(w_seq.size(), seq_ctr);
      w_pre.insert(w_pre.size(), req.prereq_seq);
      w_type.insert(w_type.size(), req.job_type);
      expected_q.insert(expected_q.size(), mk(KIND_ADDED, seq_ctr, '0, '0));
    end else begin
      if (req.slot < RUN_SLOTS) s_busy[req.slot] = 1'b0;
      expected_q.insert(expected_q.size(), mk(KIND_FINISHED, '0, '0, '0));
    end
    run_dispatch_pass();
    expected_q[$].last = 1'b1;
  endtask

  task automatic compare_result();
    outcome_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result kind %0d seq %0d", rsp.kind, rsp.seq);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (rsp.kind !== e.kind) begin
      $error("kind: expected %0d, got %0d", e.kind, rsp.kind); fail_count++;
    end
    if (rsp.seq !== e.seq) begin
      $error("seq: expected %0d, got %0d", e.seq, rsp.seq); fail_count++;
    end
    if (rsp.task_type !== e.task_type) begin
      $error("task_type: expected %0d, got %0d", e.task_type, rsp.task_type);
      fail_count++;
    end
    if (rsp.run_slot !== e.run_slot) begin
      $error("run_slot: expected %0d, got %0d", e.run_slot, rsp.run_slot);
      fail_count++;
    end
    if (rsp.last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, rsp.last); fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
      w_seq.delete();
      w_pre.delete();
      w_type.delete();
      foreach (s_busy[i]) begin
        s_busy[i] = 1'b0; s_seq[i] = '0; s_type[i] = '0;
      end
      rr_type = 3'(TYPE_COUNT - 1);
      seq_ctr = '0;
    end else begin
      // Results first: a request accepted at this edge cannot answer at the same edge.
      if (rsp.valid && rsp.ready) compare_result();
      if (req.valid && req.ready) predict_request();
    end
    pending = expected_q.size();
  end
endmodule

### sim/typed_task_dispatch_scheduler_tb.sv
// Top of the scheduler testbench: clock, reset, request stimulus, response stalls, verdict.
module typed_task_dispatch_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdsch_pkg::*;

  localparam int DOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 0;
  int   idle_cycles = 0;
  logic [31:0] issued_seq = 0;

  tdsch_req_if req ();
  tdsch_rsp_if rsp ();

  typed_task_dispatch_scheduler i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  tdsch_checker i_checker (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                           .fail_count(fail_count), .pending(pending));

  always #2 clk = ~clk;

  // The receiver decides its ready at each falling edge. A hold-off keeps it low
  // for a long stretch so that the output is held and the request side stalls.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= DOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one request and waits for its transfer; random idle cycles come first.
  // The request is driven at a falling edge, after the previous one was dropped and the idle cycles are over.
  task automatic send_request(logic c, logic [2:0] wt, logic [31:0] pre, logic [1:0] sl);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    req.valid <= 1'b1;
    req.cmd <= c;
    req.job_type <= wt;
    req.prereq_seq <= pre;
    req.slot <= sl;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (c == CMD_ADD) issued_seq = issued_seq + 1;
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic add_task(logic [2:0] wt, logic [31:0] pre);
    send_request(CMD_ADD, wt, pre, '0);
  endtask

  task automatic finish_slot(logic [1:0] sl);
    send_request(CMD_FINISH, 3'($urandom_range(7)), $urandom(), sl);
  endtask

  // Mostly well-formed traffic: adds whose prerequisite is a recent sequence or
  // none, and finishes of real slots; a little noise with random prerequisites and finishes of slot 3.
  task automatic random_request();
    int r;
    logic [31:0] pre;
    r = $urandom_range(99);
    if (r < 55) begin
      if ($urandom_range(2) == 0 || issued_seq == 0) pre = 0;
      else if ($urandom_range(9) == 0) pre = $urandom();
      else pre = issued_seq - $urandom_range(issued_seq > 4 ? 4 : issued_seq - 1);
      add_task(3'($urandom_range(7)), pre);
    end else if (r < 95) begin
      finish_slot(2'($urandom_range(RUN_SLOTS - 1)));
    end else begin
      finish_slot(2'd3);
    end
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_ADD;
    req.job_type = '0;
    req.prereq_seq = '0;
    req.slot = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every type, extreme prerequisites, self prerequisite, a blocked type
    // with an unblocked younger task, bad finishes and the full set of slots.
    add_task(3'd0, 32'd0);
    add_task(3'd7, 32'hFFFF_FFFF);
    add_task(3'd1, 32'd4);
    add_task(3'd1, 32'd0);
    add_task(3'd2, 32'd5);
    add_task(3'd3, 32'd0);
    add_task(3'd4, 32'd0);
    add_task(3'd5, 32'd1);
    add_task(3'd6, 32'hAAAA_5555);
    finish_slot(2'd0);
    finish_slot(2'd3);
    finish_slot(2'd1);
    finish_slot(2'd2);
    finish_slot(2'd0);
    finish_slot(2'd1);
    finish_slot(2'd2);
    finish_slot(2'd1);
    add_task(3'd7, 32'd0);
    finish_slot(2'd0);
    finish_slot(2'd2);
    drain();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int i = 0; i < 23; i++) random_request();
      drain();
    end

    // Pressure: the receiver holds off while adds keep coming in.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) add_task(3'($urandom_range(7)), 32'd0);
    join
    for (int i = 0; i < 10; i++) finish_slot(2'($urandom_range(RUN_SLOTS - 1)));
    drain();

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

### files.f
rtl/tdsch_pkg.sv
rtl/tdsch_if.sv
rtl/tdsch_wait_store.sv
rtl/typed_task_dispatch_scheduler.sv
sim/tdsch_checker.sv
sim/typed_task_dispatch_scheduler_tb.sv
